>>> rtl/ctwb_pkg.sv
// shared widths, constants and stage types of the cmyk white trap blend
`default_nettype none

package ctwb_pkg;

  // sample width and full-scale value
  localparam int unsigned SampleBits = 16;
  localparam logic [SampleBits-1:0] Max = '1;

  // working widths
  localparam int unsigned SumW   = SampleBits + 2;       // c + m + y
  localparam int unsigned DevW   = SampleBits + 3;       // 3 * (|c-m| + |c-y|)
  localparam int unsigned ProdW  = 2 * SampleBits;       // v * (max - a)
  localparam int unsigned PsW    = SumW + SampleBits;    // (c + m + y) * a
  localparam int unsigned Q1W    = SampleBits + 3;       // floor(2 * ps / max)

  // floor(x / 9) as (x * RecM) >> RecShift, exact for every Q1W-bit x
  localparam int unsigned RecShift = Q1W + 4;
  localparam int unsigned RecW     = SampleBits + 4;
  localparam int unsigned RecProdW = Q1W + RecW;
  localparam logic [63:0] RecFull  = ((64'd1 << RecShift) + 64'd8) / 64'd9;
  localparam logic [RecW-1:0] RecM = RecFull[RecW-1:0];

  // stream payload widths, whole bytes
  localparam int unsigned InW  = ((5 * SampleBits + 7) / 8) * 8;
  localparam int unsigned OutW = ((4 * SampleBits + 7) / 8) * 8;

  typedef logic [SampleBits-1:0] sample_t;

  // after neutral test
  typedef struct packed {
    sample_t         c;
    sample_t         m;
    sample_t         y;
    sample_t         k;
    sample_t         a;
    sample_t         inv;
    logic [SumW-1:0] sum;
    logic            blend;
  } s1_t;

  // after the multipliers
  typedef struct packed {
    sample_t          c;
    sample_t          m;
    sample_t          y;
    sample_t          k;
    logic [ProdW-1:0] pc;
    logic [ProdW-1:0] pm;
    logic [ProdW-1:0] py;
    logic [PsW-1:0]   ps;
    logic             blend;
  } s2_t;

  // after division by max, pass-through already selected for c, m, y
  typedef struct packed {
    sample_t        c;
    sample_t        m;
    sample_t        y;
    sample_t        k;
    logic [Q1W-1:0] q1;
    logic           blend;
  } s3_t;

  // after division by nine
  typedef struct packed {
    sample_t c;
    sample_t m;
    sample_t y;
    sample_t k;
    sample_t kadd;
    logic    blend;
  } s4_t;

  // output register
  typedef struct packed {
    sample_t c;
    sample_t m;
    sample_t y;
    sample_t k;
    logic    blend;
  } out_t;

endpackage

`default_nettype wire

>>> rtl/ctwb_detect.sv
// stage one: near-neutral test, channel sum and inverse weight
`default_nettype none

module ctwb_detect (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire ctwb_pkg::sample_t          c_i,
  input  wire ctwb_pkg::sample_t          m_i,
  input  wire ctwb_pkg::sample_t          y_i,
  input  wire ctwb_pkg::sample_t          k_i,
  input  wire ctwb_pkg::sample_t          a_i,
  input  wire logic                       ready_i,
  output logic                            ready_o,
  output logic                            valid_o,
  output ctwb_pkg::s1_t                   data_o
);

  localparam int unsigned N = ctwb_pkg::SampleBits;

  ctwb_pkg::sample_t             mx, dcm, dcy;
  logic [N:0]                    dev;
  logic [ctwb_pkg::DevW-1:0]     dev3;
  ctwb_pkg::s1_t                 data_d, data_q;
  logic                          valid_q;

  // largest channel and deviation from neutral
  always_comb begin
    mx = c_i;
    if (m_i > mx) mx = m_i;
    if (y_i > mx) mx = y_i;
    dcm  = (c_i > m_i) ? (c_i - m_i) : (m_i - c_i);
    dcy  = (c_i > y_i) ? (c_i - y_i) : (y_i - c_i);
    dev  = (N+1)'(dcm) + (N+1)'(dcy);
    dev3 = ctwb_pkg::DevW'({dev, 1'b0}) + ctwb_pkg::DevW'(dev);
  end

  // next stage contents
  always_comb begin
    data_d.c     = c_i;
    data_d.m     = m_i;
    data_d.y     = y_i;
    data_d.k     = k_i;
    data_d.a     = a_i;
    data_d.inv   = ctwb_pkg::Max - a_i;
    data_d.sum   = ctwb_pkg::SumW'(c_i) + ctwb_pkg::SumW'(m_i) + ctwb_pkg::SumW'(y_i);
    data_d.blend = (a_i != '0) && (dev3 < ctwb_pkg::DevW'(mx));
  end

  assign ready_o = !valid_q || ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

>>> rtl/ctwb_mul.sv
// stage two: fade products and black gain product
`default_nettype none

module ctwb_mul (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire ctwb_pkg::s1_t data_i,
  input  wire logic          ready_i,
  output logic               ready_o,
  output logic               valid_o,
  output ctwb_pkg::s2_t      data_o
);

  ctwb_pkg::s2_t data_d, data_q;
  logic          valid_q;

  // one multiplier per channel plus one for the black gain
  always_comb begin
    data_d.c     = data_i.c;
    data_d.m     = data_i.m;
    data_d.y     = data_i.y;
    data_d.k     = data_i.k;
    data_d.pc    = ctwb_pkg::ProdW'(data_i.c) * ctwb_pkg::ProdW'(data_i.inv);
    data_d.pm    = ctwb_pkg::ProdW'(data_i.m) * ctwb_pkg::ProdW'(data_i.inv);
    data_d.py    = ctwb_pkg::ProdW'(data_i.y) * ctwb_pkg::ProdW'(data_i.inv);
    data_d.ps    = ctwb_pkg::PsW'(data_i.sum) * ctwb_pkg::PsW'(data_i.a);
    data_d.blend = data_i.blend;
  end

  assign ready_o = !valid_q || ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

>>> rtl/ctwb_reduce.sv
// stage three: division of the products by full scale
`default_nettype none

module ctwb_reduce (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire ctwb_pkg::s2_t data_i,
  input  wire logic          ready_i,
  output logic               ready_o,
  output logic               valid_o,
  output ctwb_pkg::s3_t      data_o
);

  localparam int unsigned N = ctwb_pkg::SampleBits;

  // floor(p / max) for p <= max * max: high part plus one carry test
  function automatic ctwb_pkg::sample_t div_max(input logic [ctwb_pkg::ProdW-1:0] p);
    ctwb_pkg::sample_t hi;
    ctwb_pkg::sample_t lo;
    logic [N:0]        s;
    hi = p[ctwb_pkg::ProdW-1:N];
    lo = p[N-1:0];
    s  = (N+1)'(hi) + (N+1)'(lo);
    return hi + N'(s >= (N+1)'(ctwb_pkg::Max));
  endfunction

  logic [ctwb_pkg::PsW:0]     pw;
  logic [N+2:0]               ah;
  ctwb_pkg::sample_t          bl;
  logic [N+3:0]               x;
  logic [3:0]                 a2;
  logic [N:0]                 y2;
  ctwb_pkg::s3_t              data_d, data_q;
  logic                       valid_q;

  // floor(2 * ps / max), folded twice, then one carry test
  always_comb begin
    pw = {data_i.ps, 1'b0};
    ah = pw[ctwb_pkg::PsW:N];
    bl = pw[N-1:0];
    x  = (N+4)'(ah) + (N+4)'(bl);
    a2 = x[N+3:N];
    y2 = (N+1)'(x[N-1:0]) + (N+1)'(a2);
  end

  // fade results, or the original samples when the blend is off
  always_comb begin
    data_d.c     = data_i.blend ? div_max(data_i.pc) : data_i.c;
    data_d.m     = data_i.blend ? div_max(data_i.pm) : data_i.m;
    data_d.y     = data_i.blend ? div_max(data_i.py) : data_i.y;
    data_d.k     = data_i.k;
    data_d.q1    = ah + ctwb_pkg::Q1W'(a2)
                 + ctwb_pkg::Q1W'(y2 >= (N+1)'(ctwb_pkg::Max));
    data_d.blend = data_i.blend;
  end

  assign ready_o = !valid_q || ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

>>> rtl/ctwb_recip.sv
// stage four: division of the black gain by nine through a reciprocal
`default_nettype none

module ctwb_recip (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire ctwb_pkg::s3_t data_i,
  input  wire logic          ready_i,
  output logic               ready_o,
  output logic               valid_o,
  output ctwb_pkg::s4_t      data_o
);

  logic [ctwb_pkg::RecProdW-1:0] prod;
  ctwb_pkg::s4_t                 data_d, data_q;
  logic                          valid_q;

  // multiply by the scaled reciprocal of nine and keep the high part
  always_comb begin
    prod = ctwb_pkg::RecProdW'(data_i.q1) * ctwb_pkg::RecProdW'(ctwb_pkg::RecM);
    data_d.c     = data_i.c;
    data_d.m     = data_i.m;
    data_d.y     = data_i.y;
    data_d.k     = data_i.k;
    data_d.kadd  = prod[ctwb_pkg::RecProdW-1:ctwb_pkg::RecShift];
    data_d.blend = data_i.blend;
  end

  assign ready_o = !valid_q || ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

>>> rtl/cmyk_white_trap_blend.sv
// top level of the cmyk white trap blend pipeline
`default_nettype none

// Takes one pixel beat per clock and delivers one result beat per pixel, in
// order, from the output register once it has passed the stages below.
// The five register stages are: near-neutral test, the four multipliers,
// division by full scale, the reciprocal multiply that divides the black
// gain by nine, and the black saturation with the output register. Each
// stage has its own valid bit and takes a new beat whenever it is empty or
// its contents move on, so bubbles close up and the input keeps taking
// beats while a finished result waits at the output. When the pipeline is
// full and the output is stalled, s_axis_tready drops.

module cmyk_white_trap_blend (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // cyan_in, magenta_in, yellow_in, black_in, mask_weight, zero pad
  input  wire logic [ctwb_pkg::InW-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // cyan_out, magenta_out, yellow_out, black_out, zero pad
  output logic [ctwb_pkg::OutW-1:0]      m_axis_tdata,
  // was_blended
  output logic [0:0]                     m_axis_tuser
);

  localparam int unsigned N = ctwb_pkg::SampleBits;

  logic          v1, v2, v3, v4;
  logic          r2, r3, r4, r5;
  ctwb_pkg::s1_t s1;
  ctwb_pkg::s2_t s2;
  ctwb_pkg::s3_t s3;
  ctwb_pkg::s4_t s4;
  logic [N:0]    ksum;
  ctwb_pkg::out_t out_d, out_q;
  logic          out_valid_q;

  ctwb_detect u_detect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .c_i     (s_axis_tdata[N-1:0]),
    .m_i     (s_axis_tdata[2*N-1:N]),
    .y_i     (s_axis_tdata[3*N-1:2*N]),
    .k_i     (s_axis_tdata[4*N-1:3*N]),
    .a_i     (s_axis_tdata[5*N-1:4*N]),
    .ready_i (r2),
    .ready_o (s_axis_tready),
    .valid_o (v1),
    .data_o  (s1)
  );

  ctwb_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .data_i  (s1),
    .ready_i (r3),
    .ready_o (r2),
    .valid_o (v2),
    .data_o  (s2)
  );

  ctwb_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .data_i  (s2),
    .ready_i (r4),
    .ready_o (r3),
    .valid_o (v3),
    .data_o  (s3)
  );

  ctwb_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3),
    .data_i  (s3),
    .ready_i (r5),
    .ready_o (r4),
    .valid_o (v4),
    .data_o  (s4)
  );

  // black plus gain, saturated at full scale, when blended; black unchanged otherwise
  always_comb begin
    ksum        = (N+1)'(s4.k) + (N+1)'(s4.kadd);
    out_d.c     = s4.c;
    out_d.m     = s4.m;
    out_d.y     = s4.y;
    out_d.k     = !s4.blend ? s4.k : (ksum[N] ? ctwb_pkg::Max : ksum[N-1:0]);
    out_d.blend = s4.blend;
  end

  assign r5 = !out_valid_q || m_axis_tready;

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (r5) begin
      out_valid_q <= v4;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (r5 && v4) begin
      out_q <= out_d;
    end
  end

  // output beat packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ctwb_pkg::OutW'({out_q.k, out_q.y, out_q.m, out_q.c});
  assign m_axis_tuser  = out_q.blend;

  // a ready sink lets the whole pipeline move
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  // blended black never drops below its input
  a_black_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4 && r5 && s4.blend) |=> (m_axis_tdata[4*N-1:3*N] >= $past(s4.k)))
    else $error("blended black below input black");

  // pass-through keeps black unchanged
  a_black_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4 && r5 && !s4.blend) |=> (m_axis_tdata[4*N-1:3*N] == $past(s4.k)))
    else $error("pass-through black changed");

  // every loaded beat leaves the output register valid and flagged with its blend bit
  a_flag_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4 && r5) |=> (m_axis_tvalid && (m_axis_tuser[0] == $past(s4.blend))))
    else $error("output flag does not follow stage four");

endmodule

`default_nettype wire
